// File: design/prime_sieve_counter_defines.svh
// Assertion macros shared by the prime sieve counter modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef PRIME_SIEVE_COUNTER_DEFINES_SVH
`define PRIME_SIEVE_COUNTER_DEFINES_SVH

// Check sampled on clock, ignored while reset is high.
`define PSC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check sampled on clock that also holds across reset.
`define PSC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/psc_pkg.sv
// Shared types and constants of the prime sieve counter.
// No dependencies; used by psc_ctrl, psc_datapath and prime_sieve_counter.
package psc_pkg;

   localparam int LIMIT_W = 17;
   localparam int COUNT_W = 13;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE       = 4'd0,
      OP_LOAD       = 4'd1,
      OP_CLEAR      = 4'd2,
      OP_SQUARE     = 4'd3,
      OP_MARK_INIT  = 4'd4,
      OP_MARK       = 4'd5,
      OP_SCAN       = 4'd6,
      OP_SET_PRIME  = 4'd7,
      OP_COUNT_INIT = 4'd8,
      OP_COUNT      = 4'd9,
      OP_FLUSH      = 4'd10,
      OP_FINISH     = 4'd11
   } op_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic below_two; // limit below two
      logic ptr_last;  // sweep pointer at last entry
      logic sq_le_n;   // prime squared within limit
      logic mark_end;  // multiple beyond the range
      logic scan_end;  // scan ran off the range
      logic marked;    // scanned entry is composite
      logic out_free;  // result register can take a new item
   } status_type;

endpackage

// File: design/prime_sieve_counter.sv
// prime_sieve_counter top level (depends on psc_pkg, psc_ctrl, psc_datapath): takes an
// upper limit per item and returns how many primes lie in 2..limit, by a sieve of
// Eratosthenes over a one-bit mark memory of MAX_LIMIT-1 entries, entry i standing for
// value i+2. Limits above MAX_LIMIT saturate to it; a limit below two returns zero at once.
// One item is worked at a time. The mark memory has one write port and one read port;
// the work is a clear sweep over the range, marking of the multiples of each sieving
// prime, a scan of the entries up to the last sieving prime, a count sweep over the
// range and a hand-over. The result sits in an output register, so a new item is taken
// as soon as the previous one has been written there, even while the receiver still
// stalls it.

module prime_sieve_counter #(
   parameter int MAX_LIMIT = 65536   // largest limit sieved, at least 4
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [psc_pkg::LIMIT_W-1:0] req_limit,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [psc_pkg::COUNT_W-1:0] rsp_prime_count
);
   import psc_pkg::*;

   op_type     op;      // one datapath operation per cycle
   status_type status;  // flags that steer the sequencer

   // sequencer: idle, clear sweep, square/test, mark, scan, count sweep, hand-over
   psc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   // registers, squaring multiplier, mark memory and prime counter
   psc_datapath #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_limit       (req_limit),
      .op              (op),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_prime_count (rsp_prime_count)
   );

endmodule

// File: design/psc_ctrl.sv
// Sequencer of the prime sieve counter: clear, mark, scan and count phases.
// Depends on psc_pkg and prime_sieve_counter_defines.svh.
`include "prime_sieve_counter_defines.svh"

module psc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  psc_pkg::status_type status,
   output psc_pkg::op_type     op
);
   import psc_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_CLEAR     = 10'b00_0000_0010,
      S_SQUARE    = 10'b00_0000_0100,
      S_TEST      = 10'b00_0000_1000,
      S_MARK      = 10'b00_0001_0000,
      S_SCAN      = 10'b00_0010_0000,
      S_SCAN_TEST = 10'b00_0100_0000,
      S_COUNT     = 10'b00_1000_0000,
      S_FLUSH     = 10'b01_0000_0000,
      S_DONE      = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            if (status.below_two) begin
               state_in = S_DONE;
            end else begin
               op = OP_CLEAR;
               if (status.ptr_last) begin
                  state_in = S_SQUARE;
               end
            end
         end
         S_SQUARE: begin
            op       = OP_SQUARE;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (status.sq_le_n) begin
               op       = OP_MARK_INIT;
               state_in = S_MARK;
            end else begin
               op       = OP_COUNT_INIT;
               state_in = S_COUNT;
            end
         end
         S_MARK: begin
            op = OP_MARK;
            if (status.mark_end) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            op = OP_SCAN;
            if (status.scan_end) begin
               state_in = S_SQUARE;
            end else begin
               state_in = S_SCAN_TEST;
            end
         end
         S_SCAN_TEST: begin
            if (status.marked) begin
               state_in = S_SCAN;
            end else begin
               op       = OP_SET_PRIME;
               state_in = S_SQUARE;
            end
         end
         S_COUNT: begin
            op = OP_COUNT;
            if (status.ptr_last) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            op       = OP_FLUSH;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               op       = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PSC_ASSERT(a_load_starts_clear, req_valid && !req_stall |=> state_ff == S_CLEAR, "load lost")

endmodule

// File: design/psc_datapath.sv
// Sieve datapath: limit, sweep pointer, prime, square, multiple, count and the mark memory.
// Depends on psc_pkg and prime_sieve_counter_defines.svh.
`include "prime_sieve_counter_defines.svh"

module psc_datapath #(
   parameter int MAX_LIMIT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [psc_pkg::LIMIT_W-1:0] req_limit,
   input  psc_pkg::op_type             op,
   output psc_pkg::status_type         status,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [psc_pkg::COUNT_W-1:0] rsp_prime_count
);
   import psc_pkg::*;

   localparam int VW    = $clog2(MAX_LIMIT + 1);  // limit value
   localparam int AW    = $clog2(MAX_LIMIT - 1);  // mark address
   localparam int DEPTH = MAX_LIMIT - 1;
   localparam int PW    = VW + 1;                 // prime, may pass the range by one
   localparam int SW    = 2 * PW;                 // prime squared
   localparam int JW    = VW + 1;                 // running multiple

   logic               mem [DEPTH];
   logic               rd_data_ff;

   logic [VW-1:0]      n_ff, n_in;
   logic [VW-1:0]      ptr_ff, ptr_in;
   logic [VW-1:0]      idx_ff, idx_in;
   logic [PW-1:0]      p_ff, p_in;
   logic [SW-1:0]      sq_ff, sq_in;
   logic [JW-1:0]      j_ff, j_in;
   logic               pend_ff, pend_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               mem_we, mem_wdata, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;

   logic [31:0]        lim_wide, lim_sat;
   logic [VW-1:0]      size_w, ptr_next, idx_next;

   // limit saturates to MAX_LIMIT, the largest limit the store holds
   assign lim_wide = 32'(req_limit);
   assign lim_sat  = (lim_wide > 32'(MAX_LIMIT)) ? 32'(MAX_LIMIT) : lim_wide;

   assign size_w   = n_ff - VW'(1);
   assign ptr_next = ptr_ff + VW'(1);
   assign idx_next = idx_ff + VW'(1);

   assign status.below_two = (n_ff < VW'(2));
   assign status.ptr_last  = (ptr_next == size_w);
   assign status.sq_le_n   = (sq_ff <= SW'(n_ff));
   assign status.mark_end  = (j_ff >= JW'(size_w));
   assign status.scan_end  = (idx_next >= size_w);
   assign status.marked    = rd_data_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      n_in         = n_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      j_in         = j_ff;
      pend_in      = pend_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      mem_we       = 1'b0;
      mem_wdata    = 1'b0;
      mem_waddr    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (op)
         OP_LOAD: begin
            n_in     = lim_sat[VW-1:0];
            ptr_in   = '0;
            idx_in   = '0;
            p_in     = PW'(2);
            count_in = '0;
         end
         OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            ptr_in    = ptr_next;
         end
         OP_SQUARE: begin
            sq_in = SW'(p_ff) * SW'(p_ff);
         end
         OP_MARK_INIT: begin
            // square is within the limit here, so it fits the multiple width
            j_in = JW'(sq_ff) - JW'(2);
         end
         OP_MARK: begin
            if (!status.mark_end) begin
               mem_we    = 1'b1;
               mem_wdata = 1'b1;
               mem_waddr = j_ff[AW-1:0];
               j_in      = j_ff + JW'(p_ff);
            end
         end
         OP_SCAN: begin
            idx_in = idx_next;
            if (status.scan_end) begin
               // ran off the range: next prime lies past it and ends the sieve
               p_in = PW'(idx_next) + PW'(2);
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_next[AW-1:0];
            end
         end
         OP_SET_PRIME: begin
            p_in = PW'(idx_ff) + PW'(2);
         end
         OP_COUNT_INIT: begin
            ptr_in  = '0;
            pend_in = 1'b0;
         end
         OP_COUNT: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_ff[AW-1:0];
            ptr_in    = ptr_next;
            pend_in   = 1'b1;
            if (pend_ff && !rd_data_ff) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_FLUSH: begin
            pend_in = 1'b0;
            if (pend_ff && !rd_data_ff) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      ptr_ff       <= ptr_in;
      sq_ff        <= sq_in;
      j_ff         <= j_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         p_ff         <= PW'(2);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         p_ff         <= p_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;

   `PSC_ASSERT(a_write_in_range, mem_we |-> (VW'(mem_waddr) < size_w), "mark write past range")
   `PSC_ASSERT(a_no_low_mark, (mem_we && mem_wdata) |-> (mem_waddr >= AW'(2)), "2 or 3 marked")
   `PSC_ASSERT(a_mark_within_limit, (op == OP_MARK_INIT) |-> status.sq_le_n, "marking past limit")
   `PSC_ASSERT_RST(a_reset_no_result, reset |=> !rsp_valid_ff, "result after reset")

endmodule
